/* src/pfc_pkg.sv */
// Package for the prime factor counter: shared widths and divider constants.
// Used by pfc_div and prime_factor_count_top; depends on nothing else.
package pfc_pkg;

    // Width of one stored prime (all primes below 2048 fit).
    localparam int PRIME_W = 11;

    // Width of the factor count result.
    localparam int COUNT_W = 5;

    // Quotient bits the divider resolves in one clock cycle.
    localparam int DIV_STEPS = 3;

endpackage

/* src/prime_factor_count_top.sv */
// Top level of the prime factor counter (big omega by trial division).
// Depends on pfc_pkg and pfc_div.
//
// Usage: the request channel (req_valid, req_ready, value) carries one
// integer per transfer; the response channel (rsp_valid, rsp_ready,
// factor_count) returns its number of prime factors counted with
// multiplicity. Zero and one give a count of zero. Requests are handled
// one at a time in arrival order, and each request yields one response.
//
// After reset the block builds its prime table with a sieve held in a
// bit memory: a clearing pass over every mark, then a read and check of
// each candidate and one mark write per sieve multiple, until the table
// is full or PRIME_LIMIT is reached. req_ready stays low during that time.
//
// Each table prime p with p*p no greater than the original value is
// tried in turn and divided out for as long as it divides, on the
// shared divider, which resolves three quotient bits a cycle. A prime
// that does not divide takes a single division before the next is read.
// The result sits in an output register, so a new request is accepted
// while an earlier result waits for rsp_ready; a finished count is held
// until the output register is free.
module prime_factor_count_top #(
    parameter int VALUE_BITS  = 21,
    parameter int PRIME_LIMIT = 2000,
    parameter int PRIME_COUNT = 303
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [VALUE_BITS-1:0]        value,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [pfc_pkg::COUNT_W-1:0]  factor_count
);

    localparam int PW  = pfc_pkg::PRIME_W;
    localparam int CW  = pfc_pkg::COUNT_W;
    localparam int MW  = $clog2(PRIME_LIMIT + 1);
    localparam int KW  = $clog2(PRIME_COUNT + 1);
    localparam int AW  = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;
    localparam int SQW = (2 * PW > VALUE_BITS) ? 2 * PW : VALUE_BITS;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_SIEVE_RD,
        S_SIEVE_CHK,
        S_SIEVE_MARK,
        S_IDLE,
        S_TBL_RD,
        S_TBL_CHK,
        S_DIV,
        S_FINISH
    } state_t;

    // Control and result registers.
    state_t              state_reg, state_next;
    logic [MW-1:0]       cand_reg, cand_next;      // sieve candidate / clear address
    logic [MW-1:0]       mult_reg, mult_next;      // sieve multiple being marked
    logic [KW-1:0]       valid_cnt_reg, valid_cnt_next;
    logic [KW-1:0]       idx_reg, idx_next;
    logic [VALUE_BITS-1:0] orig_reg, orig_next;
    logic [VALUE_BITS-1:0] rest_reg, rest_next;
    logic [PW-1:0]       prime_reg, prime_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [CW-1:0]       factor_count_reg, factor_count_next;

    // Sieve mark memory and prime table memory.
    logic                mark_mem [0:PRIME_LIMIT];
    logic                mark_rd_reg;
    logic [MW-1:0]       mark_addr;
    logic                mark_we;
    logic                mark_wdata;

    logic [PW-1:0]       prime_mem [0:PRIME_COUNT-1];
    logic [PW-1:0]       prime_rd_reg;
    logic                prime_we;

    // Divider interface.
    logic                div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [PW-1:0]       div_divisor;
    logic                div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [PW-1:0]       div_remainder;

    logic [2*MW-1:0]     cand_sq;
    logic [MW:0]         mult_step;
    logic [2*PW-1:0]     prime_sq;
    logic [CW-1:0]       count_final;

    assign cand_sq     = {MW'(0), cand_reg} * {MW'(0), cand_reg};
    assign mult_step   = {1'b0, mult_reg} + {1'b0, cand_reg};
    assign prime_sq    = {PW'(0), prime_rd_reg} * {PW'(0), prime_rd_reg};
    assign count_final = count_reg + CW'(rest_reg > VALUE_BITS'(1));

    assign mark_addr    = (state_reg == S_SIEVE_MARK) ? mult_reg : cand_reg;
    assign mark_we      = (state_reg == S_CLEAR) || (state_reg == S_SIEVE_MARK);
    assign mark_wdata   = (state_reg == S_SIEVE_MARK);
    assign div_dividend = (state_reg == S_DIV) ? div_quotient : rest_reg;
    // The first division by a new prime starts before prime_reg holds it.
    assign div_divisor  = (state_reg == S_TBL_CHK) ? prime_rd_reg : prime_reg;

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_addr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[mark_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prime_we)
        begin
            prime_mem[valid_cnt_reg[AW-1:0]] <= PW'(cand_reg);
        end
        prime_rd_reg <= prime_mem[idx_reg[AW-1:0]];
    end

    pfc_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    always_comb
    begin
        state_next        = state_reg;
        cand_next         = cand_reg;
        mult_next         = mult_reg;
        valid_cnt_next    = valid_cnt_reg;
        idx_next          = idx_reg;
        orig_next         = orig_reg;
        rest_next         = rest_reg;
        prime_next        = prime_reg;
        count_next        = count_reg;
        rsp_valid_next    = rsp_valid_reg;
        factor_count_next = factor_count_reg;
        prime_we          = 1'b0;
        div_start         = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                if (cand_reg == MW'(PRIME_LIMIT))
                begin
                    cand_next  = MW'(2);
                    state_next = S_SIEVE_RD;
                end
                else
                begin
                    cand_next = cand_reg + MW'(1);
                end
            end
            S_SIEVE_RD:
            begin
                // The mark of the candidate is read here and seen next cycle.
                if (cand_reg >= MW'(PRIME_LIMIT) || valid_cnt_reg == KW'(PRIME_COUNT))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SIEVE_CHK;
                end
            end
            S_SIEVE_CHK:
            begin
                if (!mark_rd_reg)
                begin
                    prime_we       = 1'b1;
                    valid_cnt_next = valid_cnt_reg + KW'(1);
                end
                if (!mark_rd_reg && cand_sq <= (2*MW)'(PRIME_LIMIT))
                begin
                    mult_next  = cand_sq[MW-1:0];
                    state_next = S_SIEVE_MARK;
                end
                else
                begin
                    cand_next  = cand_reg + MW'(1);
                    state_next = S_SIEVE_RD;
                end
            end
            S_SIEVE_MARK:
            begin
                if (mult_step > (MW+1)'(PRIME_LIMIT))
                begin
                    cand_next  = cand_reg + MW'(1);
                    state_next = S_SIEVE_RD;
                end
                else
                begin
                    mult_next = mult_step[MW-1:0];
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    orig_next  = value;
                    rest_next  = value;
                    count_next = '0;
                    idx_next   = '0;
                    state_next = S_TBL_RD;
                end
            end
            S_TBL_RD:
            begin
                if (idx_reg == valid_cnt_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_TBL_CHK;
                end
            end
            S_TBL_CHK:
            begin
                // Stop once p*p passes the original value.
                if (prime_rd_reg < PW'(2) || SQW'(prime_sq) > SQW'(orig_reg))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    prime_next = prime_rd_reg;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_remainder == '0)
                    begin
                        // The prime divides: keep the quotient and try again.
                        rest_next  = div_quotient;
                        count_next = count_reg + CW'(1);
                        div_start  = 1'b1;
                    end
                    else
                    begin
                        idx_next   = idx_reg + KW'(1);
                        state_next = S_TBL_RD;
                    end
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next    = 1'b1;
                    factor_count_next = count_final;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            cand_reg         <= '0;
            mult_reg         <= '0;
            valid_cnt_reg    <= '0;
            idx_reg          <= '0;
            orig_reg         <= '0;
            rest_reg         <= '0;
            prime_reg        <= '0;
            count_reg        <= '0;
            rsp_valid_reg    <= 1'b0;
            factor_count_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cand_reg         <= cand_next;
            mult_reg         <= mult_next;
            valid_cnt_reg    <= valid_cnt_next;
            idx_reg          <= idx_next;
            orig_reg         <= orig_next;
            rest_reg         <= rest_next;
            prime_reg        <= prime_next;
            count_reg        <= count_next;
            rsp_valid_reg    <= rsp_valid_next;
            factor_count_reg <= factor_count_next;
        end
    end

    assign req_ready    = (state_reg == S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign factor_count = factor_count_reg;

endmodule

/* src/pfc_div.sv */
// Iterative restoring divider: a VALUE_BITS dividend by a PRIME_W divisor,
// pfc_pkg::DIV_STEPS quotient bits per cycle. Depends on pfc_pkg.
module pfc_div #(
    parameter int VALUE_BITS = 21
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [VALUE_BITS-1:0]        dividend,
    input  logic [pfc_pkg::PRIME_W-1:0]  divisor,
    output logic                         done,
    output logic [VALUE_BITS-1:0]        quotient,
    output logic [pfc_pkg::PRIME_W-1:0]  remainder
);

    localparam int NITER = (VALUE_BITS + pfc_pkg::DIV_STEPS - 1) / pfc_pkg::DIV_STEPS;
    localparam int DW    = NITER * pfc_pkg::DIV_STEPS;
    localparam int CNTW  = $clog2(NITER + 1);

    logic [DW-1:0]               shift_reg;
    logic [pfc_pkg::PRIME_W-1:0] rem_reg;
    logic [pfc_pkg::PRIME_W-1:0] divisor_reg;
    logic [CNTW-1:0]             cnt_reg;
    logic                        done_reg;

    logic [DW-1:0]               shift_next;
    logic [pfc_pkg::PRIME_W-1:0] rem_next;

    // Several compare-and-subtract steps on narrow values per cycle.
    always_comb
    begin
        logic [pfc_pkg::PRIME_W:0] trial;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        for (int s = 0; s < pfc_pkg::DIV_STEPS; s++)
        begin
            trial      = {rem_next, shift_next[DW-1]};
            shift_next = {shift_next[DW-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial         = trial - {1'b0, divisor_reg};
                shift_next[0] = 1'b1;
            end
            rem_next = trial[pfc_pkg::PRIME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNTW'(NITER);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - CNTW'(1);
                done_reg <= (cnt_reg == CNTW'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg   <= DW'(dividend);
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = shift_reg[VALUE_BITS-1:0];
    assign remainder = rem_reg;

endmodule
